/* src/gtd_pkg.sv */
// Package for the gait trough detector: widths, register codes, reset values,
// the divide-by-ten reciprocal and the structs passed between modules.
// No dependencies.
`default_nettype none

package gtd_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned HP_W     = 17;
	localparam int unsigned LEVEL_W  = 17;
	localparam int unsigned MARGIN_W = 17;
	localparam int unsigned TICKS_W  = 10;
	localparam int unsigned CFG_W    = 17;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_TROUGH_LEVEL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MARGIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd2;

	localparam logic signed [LEVEL_W-1:0] TROUGH_LEVEL_RST   = -17'sd500;
	localparam logic [MARGIN_W-1:0]       RELEASE_MARGIN_RST = 17'd1000;
	localparam logic [TICKS_W-1:0]        TIMEOUT_TICKS_RST  = 10'd10;

	// floor(a/10) == (a * DIV10_RECIP) >> DIV10_SHIFT, exact for a < 699050
	localparam int unsigned   MAG_W       = 19;
	localparam logic [18:0]   DIV10_RECIP = 19'd419431;
	localparam int unsigned   DIV10_SHIFT = 22;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] trough_level;
		logic [MARGIN_W-1:0]       release_margin;
		logic [TICKS_W-1:0]        timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic led_on;
		logic fire_ev;
		logic rel_ev;
		logic to_ev;
	} evt_t;

endpackage

`default_nettype wire

/* src/gait_trough_detector.sv */
// Gait trough detector top level: config registers, input register, result register.
// An item accepted into the input register moves on to the result register and the outputs
// once that register is free. Throughput: one item per cycle while the result register is
// free; the baseline/hp/detect logic between the registers is the one loop that sets it.
// Reset (arst_n low, asynchronous): pipeline empty, baseline and history zero, detector
// armed, LED off, timer idle, config registers back to -500 / 1000 / 10.
// Depends on gtd_pkg, gtd_hpf, gtd_detect.
`default_nettype none

module gait_trough_detector (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// config write port
	input  wire logic                                  cfg_wr_en,
	input  wire logic [gtd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [gtd_pkg::CFG_W-1:0]             cfg_data,
	// input item channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [gtd_pkg::SAMPLE_W-1:0]   sample,
	// result item channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [gtd_pkg::HP_W-1:0]            hp_value,
	output logic                                       led_on,
	output logic                                       fire_event,
	output logic                                       release_event,
	output logic                                       timeout_event
);

	gtd_pkg::cfg_t cfg_q;

	// input register
	logic                                valid_s1;
	logic signed [gtd_pkg::SAMPLE_W-1:0] sample_s1;

	// result register
	logic                                out_valid_q;
	logic signed [gtd_pkg::HP_W-1:0]     hp_q;
	gtd_pkg::evt_t                       evt_q;

	logic                                out_free;
	logic                                step_en;
	logic                                in_take;
	logic signed [gtd_pkg::HP_W-1:0]     hp;
	gtd_pkg::evt_t                       evt;

	// config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trough_level   <= gtd_pkg::TROUGH_LEVEL_RST;
			cfg_q.release_margin <= gtd_pkg::RELEASE_MARGIN_RST;
			cfg_q.timeout_ticks  <= gtd_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gtd_pkg::CFG_TROUGH_LEVEL: begin
					cfg_q.trough_level <= $signed(cfg_data[gtd_pkg::LEVEL_W-1:0]);
				end
				gtd_pkg::CFG_RELEASE_MARGIN: begin
					cfg_q.release_margin <= cfg_data[gtd_pkg::MARGIN_W-1:0];
				end
				gtd_pkg::CFG_TIMEOUT_TICKS: begin
					cfg_q.timeout_ticks <= cfg_data[gtd_pkg::TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken; the stage-1 item moves
	// into it in that case, and stage 1 takes a new item whenever it empties or moves.
	assign out_free = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
		end
	end

	// baseline tracking and high-pass value; state advances only when an item moves
	gtd_hpf u_hpf (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.sample  (sample_s1),
		.hp      (hp)
	);

	// timer, fire and release decisions
	gtd_detect u_detect (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.hp      (hp),
		.cfg     (cfg_q),
		.evt     (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			hp_q  <= hp;
			evt_q <= evt;
		end
	end

	assign out_valid     = out_valid_q;
	assign hp_value      = hp_q;
	assign led_on        = evt_q.led_on;
	assign fire_event    = evt_q.fire_ev;
	assign release_event = evt_q.rel_ev;
	assign timeout_event = evt_q.to_ev;

	// a release always leaves the LED dark
	a_rel_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && release_event |-> !led_on)
		else $error("release item with LED lit");

	// a fire not cancelled on the same item lights the LED
	a_fire_led_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fire_event && !release_event |-> led_on)
		else $error("fire item with LED dark");

	// an expiry with no new fire leaves the LED dark
	a_to_led_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timeout_event && !fire_event |-> !led_on)
		else $error("timeout item with LED lit");

	// stall only while stage 1 holds an item that cannot move on
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked item");

endmodule

`default_nettype wire

/* src/gtd_hpf.sv */
// High-pass front end: baseline <- trunc((9*baseline + sample)/10), hp = sample - baseline.
// Depends on gtd_pkg.
`default_nettype none

module gtd_hpf (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  step_en,
	input  wire logic signed [gtd_pkg::SAMPLE_W-1:0]   sample,
	output logic signed [gtd_pkg::HP_W-1:0]            hp
);

	logic signed [gtd_pkg::SAMPLE_W-1:0] baseline_q;
	logic signed [19:0]                  base_ext;
	logic signed [19:0]                  acc;
	logic signed [19:0]                  acc_neg;
	logic [gtd_pkg::MAG_W-1:0]           mag;
	logic [37:0]                         prod;
	logic [15:0]                         quot;
	logic [16:0]                         base_next17;
	logic signed [gtd_pkg::SAMPLE_W-1:0] base_next;

	always_comb begin
		base_ext    = {{4{baseline_q[15]}}, baseline_q};
		acc         = (base_ext <<< 3) + base_ext + {{4{sample[15]}}, sample};
		acc_neg     = -acc;
		// |acc| <= 327680, fits 19 bits
		mag         = acc[19] ? acc_neg[gtd_pkg::MAG_W-1:0] : acc[gtd_pkg::MAG_W-1:0];
		prod        = 38'(mag) * 38'(gtd_pkg::DIV10_RECIP);
		quot        = prod[gtd_pkg::DIV10_SHIFT +: 16];
		// truncation toward zero: divide the magnitude, then restore the sign
		base_next17 = acc[19] ? (17'd0 - {1'b0, quot}) : {1'b0, quot};
		base_next   = base_next17[15:0];
		hp          = {sample[15], sample} - {base_next[15], base_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
		end else if (step_en) begin
			baseline_q <= base_next;
		end
	end

endmodule

`default_nettype wire

/* src/gtd_detect.sv */
// Trough detection state: arm/fire/release flags, LED, reference and timeout timer.
// Depends on gtd_pkg.
`default_nettype none

module gtd_detect (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               step_en,
	input  wire logic signed [gtd_pkg::HP_W-1:0]    hp,
	input  wire gtd_pkg::cfg_t                      cfg,
	output gtd_pkg::evt_t                           evt
);

	logic                                armed_q;
	logic                                fired_q;
	logic                                led_q;
	logic signed [gtd_pkg::HP_W-1:0]     prev_hp_q;
	logic signed [gtd_pkg::HP_W-1:0]     fire_ref_q;
	logic [gtd_pkg::TICKS_W-1:0]         timer_q;

	logic                                armed_d;
	logic                                fired_d;
	logic                                led_d;
	logic signed [gtd_pkg::HP_W-1:0]     fire_ref_d;
	logic [gtd_pkg::TICKS_W-1:0]         timer_d;
	logic                                fire;
	logic                                rel;
	logic                                to;
	logic signed [18:0]                  rel_thresh;

	always_comb begin
		armed_d    = armed_q;
		fired_d    = fired_q;
		led_d      = led_q;
		fire_ref_d = fire_ref_q;
		timer_d    = timer_q;
		to         = 1'b0;

		// timer runs first
		if (timer_q != '0) begin
			timer_d = timer_q - 1'b1;
			if (timer_d == '0) begin
				to      = 1'b1;
				led_d   = 1'b0;
				armed_d = 1'b1;
			end
		end

		fire = armed_d && (hp > prev_hp_q) && (hp < cfg.trough_level);
		if (fire) begin
			led_d      = 1'b1;
			armed_d    = 1'b0;
			fired_d    = 1'b1;
			fire_ref_d = prev_hp_q;
			timer_d    = cfg.timeout_ticks;
		end

		// release checks the reference just stored, if any
		rel_thresh = {{2{fire_ref_d[16]}}, fire_ref_d} + $signed({2'b00, cfg.release_margin});
		rel = fired_d && ($signed({{2{hp[16]}}, hp}) > rel_thresh);
		if (rel) begin
			led_d   = 1'b0;
			fired_d = 1'b0;
			armed_d = 1'b1;
			timer_d = '0;
		end

		evt.led_on  = led_d;
		evt.fire_ev = fire;
		evt.rel_ev  = rel;
		evt.to_ev   = to;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b1;
			fired_q    <= 1'b0;
			led_q      <= 1'b0;
			prev_hp_q  <= '0;
			fire_ref_q <= '0;
			timer_q    <= '0;
		end else if (step_en) begin
			armed_q    <= armed_d;
			fired_q    <= fired_d;
			led_q      <= led_d;
			prev_hp_q  <= hp;
			fire_ref_q <= fire_ref_d;
			timer_q    <= timer_d;
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for gait_trough_detector: a scoreboard class tracks the
// baseline, high-pass and trough/release/timeout state and checks every result item.
// Depends on gtd_pkg and the gait_trough_detector RTL.
`timescale 1ns / 1ps

typedef struct packed {
	logic signed [gtd_pkg::HP_W-1:0] hp;
	logic                            led;
	logic                            fire;
	logic                            rel;
	logic                            tmo;
} step_result_t;

// Tracks detector state and the results still owed by the block.
class trough_scoreboard;
	step_result_t                         results_due[$];
	int                                   errors;
	logic signed [gtd_pkg::LEVEL_W-1:0]   level;
	logic [gtd_pkg::MARGIN_W-1:0]         margin;
	logic [gtd_pkg::TICKS_W-1:0]          ticks;
	logic signed [gtd_pkg::SAMPLE_W-1:0]  baseline;
	logic signed [17:0]                   prev_hp;
	logic signed [17:0]                   fire_ref;
	logic                                 armed;
	logic                                 fired;
	logic                                 led;
	logic [gtd_pkg::TICKS_W-1:0]          timer;

	function new();
		errors   = 0;
		level    = gtd_pkg::TROUGH_LEVEL_RST;
		margin   = gtd_pkg::RELEASE_MARGIN_RST;
		ticks    = gtd_pkg::TIMEOUT_TICKS_RST;
		baseline = '0;
		prev_hp  = '0;
		fire_ref = '0;
		armed    = 1'b1;
		fired    = 1'b0;
		led      = 1'b0;
		timer    = '0;
	endfunction

	function void write_register(logic [gtd_pkg::CFG_IDX_W-1:0] idx,
			logic [gtd_pkg::CFG_W-1:0] data);
		case (idx)
			gtd_pkg::CFG_TROUGH_LEVEL:   level = data;
			gtd_pkg::CFG_RELEASE_MARGIN: margin = data;
			gtd_pkg::CFG_TIMEOUT_TICKS:  ticks = data[gtd_pkg::TICKS_W-1:0];
			default: ;
		endcase
	endfunction

	// One sample in, one result owed.
	function void note_sample(logic signed [gtd_pkg::SAMPLE_W-1:0] s);
		int                 next_base;
		logic signed [17:0] hp;
		step_result_t       r;
		// SV integer divide truncates toward zero
		next_base = (9 * int'(baseline) + int'(s)) / 10;
		baseline  = next_base[gtd_pkg::SAMPLE_W-1:0];
		hp        = 18'(int'(s) - next_base);
		r         = '0;
		if (timer != 0) begin
			timer--;
			if (timer == 0) begin
				r.tmo = 1'b1;
				led   = 1'b0;
				armed = 1'b1;
			end
		end
		if (armed && hp > prev_hp && hp < level) begin
			r.fire   = 1'b1;
			led      = 1'b1;
			armed    = 1'b0;
			fired    = 1'b1;
			fire_ref = prev_hp;
			timer    = ticks;
		end
		// release sees a reference stored on this same sample
		if (fired && longint'(hp) > longint'(fire_ref) + longint'(margin)) begin
			r.rel = 1'b1;
			led   = 1'b0;
			fired = 1'b0;
			armed = 1'b1;
			timer = '0;
		end
		prev_hp = hp;
		r.hp    = hp[gtd_pkg::HP_W-1:0];
		r.led   = led;
		results_due.push_back(r);
	endfunction

	function int pending();
		return results_due.size();
	endfunction

	function void check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_result(logic signed [gtd_pkg::HP_W-1:0] hp, logic led_o,
			logic fire_o, logic rel_o, logic tmo_o);
		step_result_t want;
		if (results_due.size() == 0) begin
			$display("%0t: result with none expected, actual hp_value %0d", $time, hp);
			errors++;
			return;
		end
		want = results_due.pop_front();
		check_field("hp_value", int'(want.hp), int'(hp));
		check_field("led_on", want.led, led_o);
		check_field("fire_event", want.fire, fire_o);
		check_field("release_event", want.rel, rel_o);
		check_field("timeout_event", want.tmo, tmo_o);
	endfunction
endclass

module testbench;

	localparam int STALL_LIMIT = 1000;   // cycles with no item moving on either side

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 cfg_wr_en;
	logic [gtd_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [gtd_pkg::CFG_W-1:0]            cfg_data;
	logic                                 in_valid;
	logic                                 in_stall;
	logic signed [gtd_pkg::SAMPLE_W-1:0]  sample;
	logic                                 out_valid;
	logic                                 out_stall;
	logic signed [gtd_pkg::HP_W-1:0]      hp_value;
	logic                                 led_on;
	logic                                 fire_event;
	logic                                 release_event;
	logic                                 timeout_event;

	trough_scoreboard sb;
	int               burst_left = 0;
	int               samples_fed = 0;

	gait_trough_detector u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hp_value      (hp_value),
		.led_on        (led_on),
		.fire_event    (fire_event),
		.release_event (release_event),
		.timeout_event (timeout_event)
	);

	always #5 clk = ~clk;

	// Offer one sample (saturated to 16 bits), wait for it to be taken, then maybe pause.
	task automatic feed(input int value);
		logic signed [gtd_pkg::SAMPLE_W-1:0] s;
		int                                  gap;
		if (value > 32767)
			s = 16'sh7fff;
		else if (value < -32768)
			s = 16'sh8000;
		else
			s = 16'(value);
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s);
		samples_fed++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_register(input logic [gtd_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= gtd_pkg::CFG_W'(value);
		@(posedge clk);
		sb.write_register(idx, gtd_pkg::CFG_W'(value));
	endtask

	// Drain the block, then load all three registers.
	task automatic apply_settings(input int level, input int margin, input int ticks);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_register(gtd_pkg::CFG_TROUGH_LEVEL, level);
		write_register(gtd_pkg::CFG_RELEASE_MARGIN, margin);
		write_register(gtd_pkg::CFG_TIMEOUT_TICKS, ticks);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly stride-like dips (fall, rise, settle) with jitter; some raw noise and rails.
	task automatic run_phase(input int count);
		int                                  stop;
		int                                  depth;
		int                                  fall;
		int                                  rise;
		int                                  peak;
		int                                  k;
		int                                  mode;
		logic signed [gtd_pkg::SAMPLE_W-1:0] raw;
		stop = samples_fed + count;
		while (samples_fed < stop) begin
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				depth = $urandom_range(200, 40000);
				fall  = $urandom_range(1, 5);
				rise  = $urandom_range(1, 8);
				peak  = $urandom_range(0, 20000);
				for (k = 1; k <= fall && samples_fed < stop; k++)
					feed(-depth * k / fall + int'($urandom_range(0, 400)) - 200);
				for (k = 1; k <= rise && samples_fed < stop; k++)
					feed(-depth + (depth + peak) * k / rise + int'($urandom_range(0, 400)) - 200);
				repeat ($urandom_range(0, 4))
					if (samples_fed < stop)
						feed(peak + int'($urandom_range(0, 400)) - 200);
			end else if (mode < 9) begin
				repeat ($urandom_range(1, 10))
					if (samples_fed < stop) begin
						raw = 16'($urandom);
						feed(raw);
					end
			end else begin
				case ($urandom_range(0, 4))
					0: feed(-32768);
					1: feed(32767);
					2: feed(0);
					3: feed(-1);
					default: feed(1);
				endcase
			end
		end
	endtask

	// Result side: every accepted result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(hp_value, led_on, fire_event, release_event, timeout_event);
	end

	// Receiver stall pattern; every eighth segment is a long hold-off so the block backs up.
	initial begin : receiver
		int seg;
		int len;
		int k;
		seg = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			seg++;
			len = $urandom_range(1, 24);
			if (seg % 8 == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(30, 60)) @(posedge clk);
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						out_stall <= 1'b0;
						repeat (len) @(posedge clk);
					end
					1: repeat (len) begin
						out_stall <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
					default: for (k = 0; k < len; k++) begin
						out_stall <= (k % 3 == 2);
						@(posedge clk);
					end
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int fixed_level [4];
		int fixed_margin [4];
		int fixed_ticks [4];
		int p;
		fixed_level  = '{-500, 0, -65535, -1};
		fixed_margin = '{1000, 0, 131071, 131071};
		fixed_ticks  = '{10, 1, 1023, 1023};
		sb        = new();
		arst_n    = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= gtd_pkg::CFG_TROUGH_LEVEL;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample    <= '0;
		out_stall <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: rails, then a dip that fires and releases on the same sample.
		feed(0);
		feed(32767);
		feed(-32768);
		feed(-20000);
		// Huge margin, short timer: fire, then timeout with fired still set.
		apply_settings(-500, 131071, 3);
		feed(-32768);
		feed(-25000);
		feed(0);
		feed(0);
		feed(0);
		// Margin reachable again: late release after the timeout; then a fire with the
		// timer disabled, released later with no timeout.
		apply_settings(-500, 20000, 0);
		feed(0);
		feed(-32768);
		feed(-28000);
		feed(0);
		// One-tick timer on a long dip: expiry and refire land on the same sample.
		apply_settings(-500, 131071, 1);
		feed(-32768);
		feed(-30000);
		feed(-26000);
		feed(-20000);
		feed(0);

		for (p = 0; p < 8; p++) begin
			if (p < 4)
				apply_settings(fixed_level[p], fixed_margin[p], fixed_ticks[p]);
			else
				apply_settings(
					($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 65535))
						: -int'($urandom_range(100, 6000)),
					($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 131071))
						: int'($urandom_range(0, 6000)),
					($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 1023))
						: int'($urandom_range(1, 40)));
			run_phase(220);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
